### hdl/eptp_pkg.sv
package eptp_pkg;

    // Panel geometry in pixels.
    localparam int LONG_PIXELS   = 296;
    localparam int SHORT_PIXELS  = 128;
    localparam int BYTES_PER_ROW = SHORT_PIXELS / 8;

    // Field widths.
    localparam int ROW_W  = 9;
    localparam int BCOL_W = 4;
    localparam int Y_W    = BCOL_W + 3;
    localparam int BYTE_W = 8;
    localparam int PAT_W  = 4;

    // Fill byte for the checker pattern.
    localparam logic [BYTE_W-1:0] CHECK_BYTE = 8'hAA;

    // Framed text: 5x7 glyphs scaled by six, 34 scaled columns wide.
    localparam int NFC_SCALE  = 6;
    localparam int NFC_GLYPHS = 5;
    localparam int NFC_OX     = (LONG_PIXELS - 34 * NFC_SCALE) / 2;
    localparam int NFC_OY     = (SHORT_PIXELS - 7 * NFC_SCALE) / 2;
    localparam int NFC_W      = 5 * NFC_SCALE;
    localparam int NFC_H      = 7 * NFC_SCALE;

    // Test text: 5x7 glyphs scaled by five, slots six scaled columns apart.
    localparam int SCALE       = 5;
    localparam int TEXT_GLYPHS = 6;
    localparam int TEXT_PITCH  = 6 * SCALE;
    localparam int TEXT_OX     = (LONG_PIXELS - (7 * TEXT_PITCH - SCALE)) / 2;
    localparam int TEXT_OY     = (SHORT_PIXELS - 7 * SCALE) / 2;
    localparam int TEXT_W      = 5 * SCALE;
    localparam int TEXT_H      = 7 * SCALE;

    // Glyph start positions along the long axis, in units of the scale (framed text) or the pitch (test text).
    localparam logic [5:0] NFC_SLOT [NFC_GLYPHS] = '{6'd0, 6'd6, 6'd12, 6'd23, 6'd29};
    localparam logic [5:0] TEXT_SLOT [TEXT_GLYPHS] =
        '{6'd0, 6'd1, 6'd2, 6'd3, 6'd5, 6'd6};

    // Glyph bitmaps, one five-bit row per line, leftmost column in bit 4.
    localparam logic [4:0] NFC_FONT [NFC_GLYPHS][7] = '{
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}
    };
    localparam logic [4:0] TEXT_FONT [TEXT_GLYPHS][7] = '{
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}
    };

    // Pattern codes; codes above the last member show white.
    typedef enum logic [PAT_W-1:0] {
        PAT_CHECKER    = 4'd0,
        PAT_NFC_OK     = 4'd1,
        PAT_BLACK      = 4'd2,
        PAT_WHITE      = 4'd3,
        PAT_LONG_BARS  = 4'd4,
        PAT_SHORT_BARS = 4'd5,
        PAT_GRID       = 4'd6,
        PAT_DIAGONAL   = 4'd7,
        PAT_TARGET     = 4'd8,
        PAT_TEXT       = 4'd9
    } pattern_t;

    // Per-row facts shared by all eight pixels of a byte.
    typedef struct packed {
        logic       border_x;
        logic       grid_x;
        logic       target_x;
        logic [4:0] diag_x;
        logic       nfc_hit;
        logic [2:0] nfc_glyph;
        logic [2:0] nfc_col;
        logic       text_hit;
        logic [2:0] text_glyph;
        logic [2:0] text_col;
    } row_info_t;

    // Floor of v/3 by reciprocal multiply; exact for all seven-bit v.
    function automatic logic [5:0] div3(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd171;
        return p[14:9];
    endfunction

    // Floor of v/6; exact for v below 42.
    function automatic logic [2:0] div6(input logic [5:0] v);
        logic [11:0] p;
        p = 12'(v) * 12'd43;
        return 3'(p >> 8);
    endfunction

    // Floor of v/5; exact for v below 35.
    function automatic logic [2:0] div5(input logic [5:0] v);
        logic [11:0] p;
        p = 12'(v) * 12'd52;
        return 3'(p >> 8);
    endfunction

endpackage

### hdl/eptp_pixel.sv
module eptp_pixel (
    input  logic [eptp_pkg::PAT_W-1:0] pattern_sel,
    input  eptp_pkg::row_info_t        row_info,
    input  logic [eptp_pkg::Y_W-1:0]   y,
    output logic                       black
);

    logic [eptp_pkg::Y_W-1:0] nfc_off;
    logic [eptp_pkg::Y_W-1:0] text_off;
    logic [eptp_pkg::Y_W-1:0] my;
    logic                     nfc_in;
    logic                     text_in;
    logic [2:0]               nfc_dy;
    logic [2:0]               text_dy;
    logic [4:0]               nfc_line;
    logic [4:0]               text_line;
    logic                     nfc_dot;
    logic                     text_dot;
    logic [4:0]               diag_sum;
    logic                     y_on;

    // Glyph line within the text band along the short axis.
    always_comb begin
        nfc_off  = y - eptp_pkg::Y_W'(eptp_pkg::NFC_OY);
        text_off = y - eptp_pkg::Y_W'(eptp_pkg::TEXT_OY);
        nfc_in   = (y >= eptp_pkg::Y_W'(eptp_pkg::NFC_OY))
                   && (nfc_off < eptp_pkg::Y_W'(eptp_pkg::NFC_H));
        text_in  = (y >= eptp_pkg::Y_W'(eptp_pkg::TEXT_OY))
                   && (text_off < eptp_pkg::Y_W'(eptp_pkg::TEXT_H));
        nfc_dy   = nfc_in ? eptp_pkg::div6(6'(nfc_off)) : 3'd0;
        text_dy  = text_in ? eptp_pkg::div5(6'(text_off)) : 3'd0;
        nfc_line  = eptp_pkg::NFC_FONT[row_info.nfc_glyph][nfc_dy];
        text_line = eptp_pkg::TEXT_FONT[row_info.text_glyph][text_dy];
        nfc_dot  = row_info.nfc_hit && nfc_in && nfc_line[3'd4 - row_info.nfc_col];
        text_dot = row_info.text_hit && text_in && text_line[3'd4 - row_info.text_col];
    end

    // Short-axis helpers for stripes and the mirrored target.
    always_comb begin
        diag_sum = row_info.diag_x + y[4:0];
        my = (y < eptp_pkg::Y_W'(eptp_pkg::SHORT_PIXELS / 2)) ? y
             : eptp_pkg::Y_W'(eptp_pkg::SHORT_PIXELS - 1) - y;
        y_on = 8'(y) < 8'(eptp_pkg::SHORT_PIXELS);
    end

    // Pixel colour for the per-pixel patterns.
    always_comb begin
        black = 1'b0;
        case (pattern_sel) inside
            eptp_pkg::PAT_NFC_OK: begin
                black = row_info.border_x || (y == eptp_pkg::Y_W'(1))
                        || (y == eptp_pkg::Y_W'(eptp_pkg::SHORT_PIXELS - 2)) || nfc_dot;
            end
            eptp_pkg::PAT_SHORT_BARS: black = !y[3];
            eptp_pkg::PAT_GRID:       black = row_info.grid_x || (y[3:1] == 3'd0);
            eptp_pkg::PAT_DIAGONAL:   black = (diag_sum[4:2] == 3'd0);
            eptp_pkg::PAT_TARGET:     black = row_info.target_x || (my[3:1] == 3'd0);
            eptp_pkg::PAT_TEXT:       black = text_dot;
            default:                  black = 1'b0;
        endcase
        black = black && y_on;
    end

endmodule

### hdl/eptp_byte.sv
module eptp_byte (
    input  logic [eptp_pkg::PAT_W-1:0]  pattern_sel,
    input  logic [eptp_pkg::ROW_W-1:0]  row_index,
    input  logic [eptp_pkg::BCOL_W-1:0] byte_column,
    output logic [eptp_pkg::BYTE_W-1:0] pixel_byte
);

    eptp_pkg::row_info_t        row_info;
    logic [eptp_pkg::ROW_W-1:0] mx;
    logic [eptp_pkg::ROW_W-1:0] org;
    logic [eptp_pkg::ROW_W-1:0] off;
    logic [5:0]                 block24;
    logic [5:0]                 block12;
    logic [7:0]                 black;
    logic [7:0]                 pixel_bits;
    logic                       off_panel;
    logic                       check_edge;

    // Long-axis facts: frame, grid lines, target rings and glyph columns.
    always_comb begin
        block24 = eptp_pkg::div3(7'(row_index >> 3));
        block12 = eptp_pkg::div3(7'(row_index >> 2));
        mx = (row_index < eptp_pkg::ROW_W'(eptp_pkg::LONG_PIXELS / 2)) ? row_index
             : eptp_pkg::ROW_W'(eptp_pkg::LONG_PIXELS - 1) - row_index;
        row_info.border_x = (row_index == eptp_pkg::ROW_W'(1))
                            || (row_index == eptp_pkg::ROW_W'(eptp_pkg::LONG_PIXELS - 2));
        row_info.grid_x   = ((6'(row_index >> 3) - block24 * 6'd3) == 6'd0)
                            && (row_index[2:1] == 2'd0);
        row_info.target_x = (mx[3:1] == 3'd0);
        row_info.diag_x   = row_index[4:0];
        row_info.nfc_hit    = 1'b0;
        row_info.nfc_glyph  = 3'd0;
        row_info.nfc_col    = 3'd0;
        row_info.text_hit   = 1'b0;
        row_info.text_glyph = 3'd0;
        row_info.text_col   = 3'd0;
        org = '0;
        off = '0;
        // Glyph cells do not overlap, so at most one of them matches.
        for (int i = 0; i < eptp_pkg::NFC_GLYPHS; i++) begin
            org = eptp_pkg::ROW_W'(eptp_pkg::NFC_OX)
                  + eptp_pkg::ROW_W'(eptp_pkg::NFC_SLOT[i])
                    * eptp_pkg::ROW_W'(eptp_pkg::NFC_SCALE);
            off = row_index - org;
            if (row_index >= org && off < eptp_pkg::ROW_W'(eptp_pkg::NFC_W)) begin
                row_info.nfc_hit   = 1'b1;
                row_info.nfc_glyph = 3'(i);
                row_info.nfc_col   = eptp_pkg::div6(6'(off));
            end
        end
        for (int i = 0; i < eptp_pkg::TEXT_GLYPHS; i++) begin
            org = eptp_pkg::ROW_W'(eptp_pkg::TEXT_OX)
                  + eptp_pkg::ROW_W'(eptp_pkg::TEXT_SLOT[i]) * eptp_pkg::ROW_W'(eptp_pkg::TEXT_PITCH);
            off = row_index - org;
            if (row_index >= org && off < eptp_pkg::ROW_W'(eptp_pkg::TEXT_W)) begin
                row_info.text_hit   = 1'b1;
                row_info.text_glyph = 3'(i);
                row_info.text_col   = eptp_pkg::div5(6'(off));
            end
        end
    end

    // Eight pixel units, most significant bit first.
    for (genvar b = 0; b < 8; b++) begin : g_pixel
        eptp_pixel u_pixel (
            .pattern_sel (pattern_sel),
            .row_info    (row_info),
            .y           ({byte_column, 3'(b)}),
            .black       (black[b])
        );
        assign pixel_bits[7-b] = !black[b];
    end

    // Whole-byte patterns and address checks.
    always_comb begin
        off_panel  = (row_index >= eptp_pkg::ROW_W'(eptp_pkg::LONG_PIXELS))
                     || ({1'b0, byte_column} >= 5'(eptp_pkg::BYTES_PER_ROW));
        check_edge = (row_index < eptp_pkg::ROW_W'(4))
                     || (row_index >= eptp_pkg::ROW_W'(eptp_pkg::LONG_PIXELS - 4))
                     || (byte_column == '0)
                     || (byte_column == eptp_pkg::BCOL_W'(eptp_pkg::BYTES_PER_ROW - 1));
        pixel_byte = 8'hFF;
        if (!off_panel) begin
            case (pattern_sel) inside
                eptp_pkg::PAT_CHECKER: begin
                    if (check_edge) begin
                        pixel_byte = 8'h00;
                    end else if ((block24[0] ^ byte_column[1]) == 1'b0) begin
                        pixel_byte = eptp_pkg::CHECK_BYTE;
                    end
                end
                eptp_pkg::PAT_BLACK:     pixel_byte = 8'h00;
                eptp_pkg::PAT_LONG_BARS: pixel_byte = block12[0] ? 8'hFF : 8'h00;
                eptp_pkg::PAT_NFC_OK, eptp_pkg::PAT_SHORT_BARS, eptp_pkg::PAT_GRID,
                eptp_pkg::PAT_DIAGONAL, eptp_pkg::PAT_TARGET, eptp_pkg::PAT_TEXT: begin
                    pixel_byte = pixel_bits;
                end
                default: pixel_byte = 8'hFF;
            endcase
        end
    end

endmodule

### hdl/epaper_test_pattern_byte_generator.sv
// Pipeline: an accepted address is registered in row_reg and bcol_reg, and the word for it is
// registered in byte_reg and shown on m_tdata.
// Throughput: one word per clock unless m_tready stalls it; the address and result registers each
// hold one word, so input is taken while a finished word waits.
// Reset (aresetn low, synchronous) empties both stages and selects the white pattern.
module epaper_test_pattern_byte_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [8:0] row_index, [12:9] byte_column
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [eptp_pkg::BYTE_W-1:0] m_tdata,   // [7:0] pixel_byte
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [eptp_pkg::PAT_W-1:0]  cfg_data   // [3:0] pattern_select
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [eptp_pkg::ROW_W-1:0]  row_reg;
    logic [eptp_pkg::BCOL_W-1:0] bcol_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [eptp_pkg::BYTE_W-1:0] byte_reg;
    logic [eptp_pkg::BYTE_W-1:0] byte_next;
    logic [eptp_pkg::PAT_W-1:0]  pattern_reg;
    logic                        out_free;

    // Handshake: each stage moves on when the stage after it is empty or drained.
    always_comb begin
        out_free       = !out_valid_reg || m_tready;
        s_tready       = !in_valid_reg || out_free;
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = out_free ? in_valid_reg : out_valid_reg;
        cfg_ready      = 1'b1;
        m_tvalid       = out_valid_reg;
        m_tdata        = byte_reg;
    end

    // Pattern byte for the registered address.
    eptp_byte u_byte (
        .pattern_sel (pattern_reg),
        .row_index   (row_reg),
        .byte_column (bcol_reg),
        .pixel_byte  (byte_next)
    );

    // Control state and pattern register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pattern_reg   <= eptp_pkg::PAT_WHITE;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                pattern_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            row_reg  <= s_tdata[8:0];
            bcol_reg <= s_tdata[12:9];
        end
        if (in_valid_reg && out_free) begin
            byte_reg <= byte_next;
        end
    end

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are full");

    a_word_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free) |=> m_tvalid)
        else $error("registered address did not produce a word");

    a_off_panel_white: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free && (row_reg >= eptp_pkg::ROW_W'(eptp_pkg::LONG_PIXELS)))
        |=> (m_tdata == 8'hFF))
        else $error("address off the panel gave a non-white word");

    a_black_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free && (pattern_reg == eptp_pkg::PAT_BLACK)
         && (row_reg < eptp_pkg::ROW_W'(eptp_pkg::LONG_PIXELS)))
        |=> (m_tdata == 8'h00))
        else $error("black pattern gave a non-black word");
`endif

endmodule

### dv/eptp_byte_checker.sv
// Watches the address, pixel and pattern channels of the byte generator.
// Every address word accepted on the input side gets its expected pixel byte.
// Every pixel word accepted on the output side is compared with the oldest
// expected byte still waiting.
module eptp_byte_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [8:0] row_index, [12:9] byte_column
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [eptp_pkg::BYTE_W-1:0] m_tdata,   // [7:0] pixel_byte
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [eptp_pkg::PAT_W-1:0]  cfg_data,  // [3:0] pattern_select
    output int                          errors,
    output int                          pending
);

    // Panel size and text placement, worked out here independently of the design.
    localparam int PANEL_ROWS = 296;
    localparam int PANEL_COLS = 128;
    localparam int NFC_ZOOM   = 6;
    localparam int NFC_X0     = (PANEL_ROWS - 34 * NFC_ZOOM) / 2;
    localparam int NFC_Y0     = (PANEL_COLS - 7 * NFC_ZOOM) / 2;
    localparam int TEST_ZOOM  = 5;
    localparam int TEST_X0    = (PANEL_ROWS - (7 * 6 * TEST_ZOOM - TEST_ZOOM)) / 2;
    localparam int TEST_Y0    = (PANEL_COLS - 7 * TEST_ZOOM) / 2;

    logic [eptp_pkg::BYTE_W-1:0] expected_bytes [$];
    logic [eptp_pkg::PAT_W-1:0]  shown_pattern;

    // Glyphs of the framed text, seven rows of five bits, top row first.
    function automatic logic [34:0] nfc_glyph(input int g);
        case (g)
            0:       return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            1:       return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            2:       return {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
            3:       return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            default: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
        endcase
    endfunction

    // Glyph start along the long axis, in scaled glyph columns.
    function automatic int nfc_start(input int g);
        case (g)
            0:       return 0;
            1:       return 6;
            2:       return 12;
            3:       return 23;
            default: return 29;
        endcase
    endfunction

    // Glyphs of the test text, in the same layout.
    function automatic logic [34:0] test_glyph(input int g);
        case (g)
            0, 3:    return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            1:       return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            2:       return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            4:       return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            default: return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
        endcase
    endfunction

    // The test text leaves one empty slot between the word and the number.
    function automatic int test_start(input int g);
        return (g < 4) ? g : g + 1;
    endfunction

    // True where a scaled glyph placed at (ox, oy) covers pixel (x, y).
    function automatic bit glyph_dark(input int x, input int y, input int ox, input int oy,
                                      input logic [34:0] bits, input int zoom);
        int dx;
        int dy;
        if (x < ox || y < oy) begin
            return 1'b0;
        end
        dx = (x - ox) / zoom;
        dy = (y - oy) / zoom;
        if (dx >= 5 || dy >= 7) begin
            return 1'b0;
        end
        return bits[34 - 5 * dy - dx];
    endfunction

    // Black or white for one pixel of the per-pixel patterns.
    function automatic bit pixel_dark(input logic [eptp_pkg::PAT_W-1:0] pat,
                                      input int x, input int y);
        int mx;
        int my;
        bit hit;
        hit = 1'b0;
        case (pat)
            eptp_pkg::PAT_NFC_OK: begin
                hit = (y == 1) || (y == PANEL_COLS - 2) || (x == 1) || (x == PANEL_ROWS - 2);
                for (int g = 0; g < 5; g++) begin
                    hit |= glyph_dark(x, y, NFC_X0 + nfc_start(g) * NFC_ZOOM, NFC_Y0,
                                      nfc_glyph(g), NFC_ZOOM);
                end
            end
            eptp_pkg::PAT_SHORT_BARS: hit = ((y / 8) % 2) == 0;
            eptp_pkg::PAT_GRID:       hit = (x % 24) < 2 || (y % 16) < 2;
            eptp_pkg::PAT_DIAGONAL:   hit = ((x + y) % 32) < 4;
            eptp_pkg::PAT_TARGET: begin
                mx  = (x < PANEL_ROWS / 2) ? x : PANEL_ROWS - 1 - x;
                my  = (y < PANEL_COLS / 2) ? y : PANEL_COLS - 1 - y;
                hit = (mx % 16) < 2 || (my % 16) < 2;
            end
            eptp_pkg::PAT_TEXT: begin
                for (int g = 0; g < 6; g++) begin
                    hit |= glyph_dark(x, y, TEST_X0 + test_start(g) * 6 * TEST_ZOOM, TEST_Y0,
                                      test_glyph(g), TEST_ZOOM);
                end
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Expected pixel byte for one frame-buffer address under the given pattern.
    function automatic logic [eptp_pkg::BYTE_W-1:0] predict_byte(
        input logic [eptp_pkg::PAT_W-1:0] pat,
        input logic [8:0]                 row,
        input logic [3:0]                 col
    );
        int x;
        int y;
        logic [eptp_pkg::BYTE_W-1:0] b;
        x = row;
        b = 8'hFF;
        // Addresses off the panel read as white.
        if (x >= PANEL_ROWS || int'(col) >= PANEL_COLS / 8) begin
            return b;
        end
        case (pat)
            eptp_pkg::PAT_CHECKER: begin
                if (x < 4 || x >= PANEL_ROWS - 4 || col == 0
                    || int'(col) == PANEL_COLS / 8 - 1) begin
                    b = 8'h00;
                end else if (((x / 24) + (col / 2)) % 2 == 0) begin
                    b = 8'hAA;
                end
            end
            eptp_pkg::PAT_BLACK:     b = 8'h00;
            eptp_pkg::PAT_LONG_BARS: b = ((x / 12) % 2 == 0) ? 8'h00 : 8'hFF;
            eptp_pkg::PAT_NFC_OK, eptp_pkg::PAT_SHORT_BARS, eptp_pkg::PAT_GRID,
            eptp_pkg::PAT_DIAGONAL, eptp_pkg::PAT_TARGET, eptp_pkg::PAT_TEXT: begin
                for (int k = 0; k < 8; k++) begin
                    y = col * 8 + k;
                    if (y < PANEL_COLS && pixel_dark(pat, x, y)) begin
                        b[7 - k] = 1'b0;
                    end
                end
            end
            // White, and every code past the last pattern.
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    initial begin
        errors  = 0;
        pending = 0;
    end

    // Outputs are checked before new addresses are queued, and the pattern
    // register is followed last, as the design takes all three at the same edge.
    always @(posedge aclk) begin
        logic [eptp_pkg::BYTE_W-1:0] want;
        if (!aresetn) begin
            expected_bytes.delete();
            pending       = 0;
            shown_pattern = eptp_pkg::PAT_WHITE;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("pixel word 0x%02h with none expected", m_tdata));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("pixel_byte 0x%02h, expected 0x%02h",
                                                  m_tdata, want));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_bytes.push_back(predict_byte(shown_pattern, s_tdata[8:0], s_tdata[12:9]));
            end
            if (cfg_valid && cfg_ready) begin
                shown_pattern = cfg_data;
            end
            pending = expected_bytes.size();
        end
    end

endmodule

### dv/tb_top.sv
// Drives frame-buffer addresses and pattern selections into the byte generator
// and leaves all checking to the checker beside it.
module tb_top;

    localparam logic [eptp_pkg::PAT_W-1:0] PAT_LAST_CODE = 4'd15;  // highest unused code, shows white
    localparam int IDLE_PERCENT  = 29;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int QUIET_LIMIT   = 3000;
    localparam int PHASES        = 24;
    localparam int PHASE_WORDS   = 80;

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [15:0]                 s_tdata   = '0;   // [8:0] row_index, [12:9] byte_column
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [eptp_pkg::BYTE_W-1:0] m_tdata;          // [7:0] pixel_byte
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [eptp_pkg::PAT_W-1:0]  cfg_data  = '0;   // [3:0] pattern_select
    int                          errors;
    int                          pending;
    int                          quiet_cycles = 0;
    bit                          steady = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    epaper_test_pattern_byte_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    eptp_byte_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // The pixel side stalls at random, except during the steady stretch.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Ends the run when no word has moved on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one address word, after a random gap, and waits until it is taken.
    task automatic send_address(input int row, input int col);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, 4'(col), 9'(row)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Selects a pattern once every outstanding pixel word has come back.
    task automatic select_pattern(input logic [eptp_pkg::PAT_W-1:0] code);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [eptp_pkg::PAT_W-1:0] code;
        int row;
        int col;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // White after reset, at both corners of the address space.
        send_address(0, 0);
        send_address(511, 15);

        // Checker: the border on every side and both fill values inside.
        select_pattern(eptp_pkg::PAT_CHECKER);
        send_address(0, 7);
        send_address(3, 5);
        send_address(4, 0);
        send_address(100, 15);
        send_address(291, 7);
        send_address(292, 8);
        send_address(30, 2);
        send_address(50, 3);
        send_address(296, 6);

        // Framed text: the frame lines and a glyph stroke.
        select_pattern(eptp_pkg::PAT_NFC_OK);
        send_address(1, 4);
        send_address(294, 9);
        send_address(150, 0);
        send_address(46, 6);
        send_address(295, 15);

        // Test text inside a glyph, and the highest unused code.
        select_pattern(eptp_pkg::PAT_TEXT);
        send_address(45, 6);
        send_address(150, 8);
        select_pattern(PAT_LAST_CODE);
        send_address(100, 5);
        send_address(400, 10);

        // Every code in turn, then random codes; one stretch runs without gaps.
        for (int p = 0; p < PHASES; p++) begin
            code = (p < 16) ? 4'(p) : 4'($urandom_range(0, 15));
            select_pattern(code);
            steady = (p >= 10 && p <= 12);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if ((code == eptp_pkg::PAT_NFC_OK || code == eptp_pkg::PAT_TEXT)
                    && $urandom_range(0, 1) == 1) begin
                    // Aim at the text area, where the glyphs are.
                    row = $urandom_range(40, 260);
                    col = $urandom_range(5, 10);
                end else begin
                    row = ($urandom_range(0, 9) == 0) ? $urandom_range(296, 511)
                                                      : $urandom_range(0, 295);
                    col = $urandom_range(0, 15);
                end
                send_address(row, col);
            end
        end
        steady = 1'b0;

        // Let the last pixel words drain before the verdict.
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
